@@ sv/assert_macros.svh @@
// Assertion helpers included by the top-level RTL file.
// In synthesis builds the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ sv/sc2a_pkg.sv @@
package sc2a_pkg;

    typedef logic [7:0] t_byte;

    // Default character FIFO depth (ring holds depth-1 characters)
    localparam int FIFO_DEPTH_DEF = 256;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UP    = 2'd0,
        CFG_DOWN  = 2'd1,
        CFG_LEFT  = 2'd2,
        CFG_RIGHT = 2'd3
    } t_cfg_idx;

    // Arrow code reset values
    localparam t_byte UP_CODE_RST    = 8'd128;
    localparam t_byte DOWN_CODE_RST  = 8'd129;
    localparam t_byte LEFT_CODE_RST  = 8'd130;
    localparam t_byte RIGHT_CODE_RST = 8'd131;

    // Scan code set 1 bytes
    localparam t_byte SC_PREFIX   = 8'hE0;
    localparam t_byte SC_BREAK    = 8'h80;
    localparam t_byte SC_KEY_MASK = 8'h7F;
    localparam t_byte SC_ALT      = 8'h38;
    localparam t_byte SC_LSHIFT   = 8'h2A;
    localparam t_byte SC_RSHIFT   = 8'h36;
    localparam t_byte SC_LCTRL    = 8'h1D;
    localparam t_byte SC_CAPS     = 8'h3A;
    localparam t_byte SC_UP       = 8'h48;
    localparam t_byte SC_DOWN     = 8'h50;
    localparam t_byte SC_LEFT     = 8'h4B;
    localparam t_byte SC_RIGHT    = 8'h4D;

    // Keys covered by the character tables
    localparam int KEY_TABLE_LEN = 59;

    // Arrow codes handed from the register bank to the decoder
    typedef struct packed {
        t_byte up;
        t_byte down;
        t_byte left;
        t_byte right;
    } t_arrow_codes;

    // Spanish layout, unshifted
    localparam t_byte PLAIN_MAP [KEY_TABLE_LEN] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h27, 8'h00, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h60, 8'h2B, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
        8'h6C, 8'h6E, 8'h27, 8'h5C, 8'h00, 8'h5D,
        8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
        8'h2E, 8'h2D, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
    };

    // Spanish layout, shifted
    localparam t_byte SHIFT_MAP [KEY_TABLE_LEN] = '{
        8'h00, 8'h1B, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
        8'h2F, 8'h28, 8'h29, 8'h3D, 8'h3F, 8'h00, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h5E, 8'h2A, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
        8'h4C, 8'h4E, 8'h22, 8'h7C, 8'h00, 8'h5B,
        8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3B,
        8'h3A, 8'h5F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
    };

    // Spanish layout, AltGr held; 0 falls back to the other tables
    localparam t_byte ALTGR_MAP [KEY_TABLE_LEN] = '{
        8'h00, 8'h00, 8'h7C, 8'h40, 8'h23, 8'h7E, 8'h00, 8'h00,
        8'h7B, 8'h5B, 8'h5D, 8'h7D, 8'h5C, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h5B, 8'h5D, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h7B, 8'h7D, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Letter keys: caps lock inverts shift for these
    function automatic logic is_letter(input t_byte k);
        return (k >= 8'h10 && k <= 8'h19) || (k >= 8'h1E && k <= 8'h26) ||
               (k >= 8'h2C && k <= 8'h32);
    endfunction

endpackage

@@ sv/sc2a_in_if.sv @@
interface sc2a_in_if;
    import sc2a_pkg::*;

    logic  valid;
    logic  ready;
    logic  mode;
    t_byte scan_byte;

    modport source (output valid, output mode, output scan_byte, input ready);
    modport sink   (input valid, input mode, input scan_byte, output ready);
endinterface

@@ sv/sc2a_out_if.sv @@
interface sc2a_out_if;
    import sc2a_pkg::*;

    logic  valid;
    logic  ready;
    t_byte char_out;
    logic  char_valid;
    logic  has_key;
    logic  dropped;

    modport source (output valid, output char_out, output char_valid,
                    output has_key, output dropped, input ready);
    modport sink   (input valid, input char_out, input char_valid,
                    input has_key, input dropped, output ready);
endinterface

@@ sv/sc2a_cfg_if.sv @@
interface sc2a_cfg_if;
    import sc2a_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_byte                data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/sc2a_ram.sv @@
module sc2a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/sc2a_decoder.sv @@
module sc2a_decoder
    import sc2a_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  t_byte        i_byte,
    input  t_arrow_codes i_arrows,
    output t_byte        o_char
);

    logic r_shift, n_shift;
    logic r_ctrl, n_ctrl;
    logic r_altgr, n_altgr;
    logic r_caps, n_caps;
    logic r_prefix, n_prefix;

    t_byte key;
    t_byte alt_ch;
    t_byte ch;
    logic  up;
    logic  in_table;

    // Table lookup for a plain make code
    always_comb begin
        in_table = (i_byte < t_byte'(KEY_TABLE_LEN));
        alt_ch   = 8'h00;
        up       = r_shift ^ (is_letter(i_byte) & r_caps);
        if (in_table && r_altgr) begin
            alt_ch = ALTGR_MAP[i_byte[5:0]];
        end
        if (!in_table) begin
            ch = 8'h00;
        end else if (alt_ch != 8'h00) begin
            ch = alt_ch;
        end else if (up) begin
            ch = SHIFT_MAP[i_byte[5:0]];
        end else begin
            ch = PLAIN_MAP[i_byte[5:0]];
        end
    end

    // Byte decode: modifier tracking and character select
    always_comb begin
        n_shift  = r_shift;
        n_ctrl   = r_ctrl;
        n_altgr  = r_altgr;
        n_caps   = r_caps;
        n_prefix = r_prefix;
        o_char   = 8'h00;
        key      = i_byte & SC_KEY_MASK;

        if (i_byte == SC_PREFIX) begin
            n_prefix = 1'b1;
        end else if (r_prefix) begin
            n_prefix = 1'b0;
            if ((i_byte & SC_BREAK) != 8'h00) begin
                if (key == SC_ALT) begin
                    n_altgr = 1'b0;
                end
            end else begin
                case (i_byte)
                    SC_ALT:   n_altgr = 1'b1;
                    SC_UP:    o_char  = i_arrows.up;
                    SC_DOWN:  o_char  = i_arrows.down;
                    SC_LEFT:  o_char  = i_arrows.left;
                    SC_RIGHT: o_char  = i_arrows.right;
                    default:  o_char  = 8'h00;
                endcase
            end
        end else if ((i_byte & SC_BREAK) != 8'h00) begin
            if (key == SC_LSHIFT || key == SC_RSHIFT) begin
                n_shift = 1'b0;
            end else if (key == SC_LCTRL) begin
                n_ctrl = 1'b0;
            end
        end else if (i_byte == SC_LSHIFT || i_byte == SC_RSHIFT) begin
            n_shift = 1'b1;
        end else if (i_byte == SC_LCTRL) begin
            n_ctrl = 1'b1;
        end else if (i_byte == SC_CAPS) begin
            n_caps = ~r_caps;
        end else begin
            o_char = ch;
        end
    end

    // Modifier state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= 1'b0;
            r_ctrl   <= 1'b0;
            r_altgr  <= 1'b0;
            r_caps   <= 1'b0;
            r_prefix <= 1'b0;
        end else if (i_en) begin
            r_shift  <= n_shift;
            r_ctrl   <= n_ctrl;
            r_altgr  <= n_altgr;
            r_caps   <= n_caps;
            r_prefix <= n_prefix;
        end
    end

endmodule

@@ sv/scancode_to_ascii_fifo.sv @@
// Scan code set 1 decoder (Spanish layout) feeding a character ring FIFO.
// Every input transaction is either a scan byte (mode 0) or a pop (mode 1),
// and yields exactly one result transaction. One transaction is taken per
// clock while the receiver keeps up. The result passes through stage 1 and is
// then loaded into the output register. Stage 1 waits for the registered read
// of the character RAM; the output register follows it. The input stalls only
// when both the RAM read stage and the output register hold results that the
// receiver has not yet taken. The FIFO holds at most FIFO_DEPTH-1 characters;
// a character decoded while it is full is lost and flagged as dropped. The
// user must write arrow codes through the configuration channel only while the
// block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module scancode_to_ascii_fifo
    import sc2a_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sc2a_in_if.sink    i_in,
    sc2a_cfg_if.sink   i_cfg,
    sc2a_out_if.source o_out
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam logic [AW-1:0] PTR_LAST = AW'(FIFO_DEPTH - 1);

    // Arrow code registers
    t_arrow_codes r_arrows;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arrows.up    <= UP_CODE_RST;
            r_arrows.down  <= DOWN_CODE_RST;
            r_arrows.left  <= LEFT_CODE_RST;
            r_arrows.right <= RIGHT_CODE_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_UP:    r_arrows.up    <= i_cfg.data;
                CFG_DOWN:  r_arrows.down  <= i_cfg.data;
                CFG_LEFT:  r_arrows.left  <= i_cfg.data;
                CFG_RIGHT: r_arrows.right <= i_cfg.data;
                default:   r_arrows       <= r_arrows;
            endcase
        end
    end

    // Pipeline handshake: stage 1 waits on the RAM read, then the output register
    logic r_s1_valid;
    logic r_s1_char_valid;
    logic r_s1_has_key;
    logic r_s1_dropped;
    logic s1_move;
    logic accept;

    assign s1_move    = r_s1_valid && (!o_out.valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_move;
    assign accept     = i_in.valid && i_in.ready;

    // Decoder
    t_byte dec_char;

    sc2a_decoder u_decoder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept && !i_in.mode),
        .i_byte   (i_in.scan_byte),
        .i_arrows (r_arrows),
        .o_char   (dec_char)
    );

    // FIFO pointers and push/pop decisions
    logic [AW-1:0] r_rd, n_rd;
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] wr_inc;
    logic [AW-1:0] rd_inc;
    logic          full;
    logic          not_empty;
    logic          push;
    logic          pop;
    logic          lost;

    always_comb begin
        wr_inc    = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        rd_inc    = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        full      = (wr_inc == r_rd);
        not_empty = (r_rd != r_wr);
        push      = accept && !i_in.mode && (dec_char != 8'h00) && !full;
        lost      = accept && !i_in.mode && (dec_char != 8'h00) && full;
        pop       = accept && i_in.mode && not_empty;
        n_wr      = push ? wr_inc : r_wr;
        n_rd      = pop ? rd_inc : r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_wr <= '0;
        end else begin
            r_rd <= n_rd;
            r_wr <= n_wr;
        end
    end

    // Character store
    t_byte ram_rdata;

    sc2a_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_wr),
        .i_wdata (dec_char),
        .i_re    (pop),
        .i_raddr (r_rd),
        .o_rdata (ram_rdata)
    );

    // Stage 1: result flags, character arrives from RAM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_char_valid <= pop;
            r_s1_has_key    <= (n_rd != n_wr);
            r_s1_dropped    <= lost;
        end
    end

    // Output register
    logic  r_out_valid;
    t_byte r_out_char;
    logic  r_out_char_valid;
    logic  r_out_has_key;
    logic  r_out_dropped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_char       <= r_s1_char_valid ? ram_rdata : 8'h00;
            r_out_char_valid <= r_s1_char_valid;
            r_out_has_key    <= r_s1_has_key;
            r_out_dropped    <= r_s1_dropped;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.char_out   = r_out_char;
    assign o_out.char_valid = r_out_char_valid;
    assign o_out.has_key    = r_out_has_key;
    assign o_out.dropped    = r_out_dropped;

    // Checks
    `ASSERT_ALWAYS(a_no_push_pop, i_clk, !(push && pop), "push and pop in one cycle")
    `ASSERT_CLK(a_push_not_empty, i_clk, i_rst_n, push |=> (r_rd != r_wr), "push left FIFO empty")
    `ASSERT_CLK(a_s1_holds, i_clk, i_rst_n, (r_s1_valid && !s1_move) |=> r_s1_valid, "stage 1 lost")
    `ASSERT_CLK(a_drop_no_char, i_clk, i_rst_n, r_s1_dropped && r_s1_valid |-> !r_s1_char_valid, "drop on pop")

endmodule

@@ sim/tb.sv @@
module tb;
    import sc2a_pkg::*;

    localparam logic MODE_SCAN = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam int RING_CAP        = FIFO_DEPTH_DEF - 1;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int CYCLE_LIMIT     = 400000;

    // One result transaction, field by field
    typedef struct packed {
        t_byte char_out;
        logic  char_valid;
        logic  has_key;
        logic  dropped;
    } t_key_result;

    // Directed row: when typed is set, want is the result to see
    typedef struct packed {
        logic        mode;
        t_byte       scan;
        logic        typed;
        t_key_result want;
    } t_key_row;

    localparam t_key_result NO_CHK = '0;

    // Spanish layout lookups for the predictor
    localparam t_byte PLAIN_KEYS [KEY_TABLE_LEN] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h27, 8'h00, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h60, 8'h2B, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
        8'h6C, 8'h6E, 8'h27, 8'h5C, 8'h00, 8'h5D,
        8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
        8'h2E, 8'h2D, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
    };

    localparam t_byte UPPER_KEYS [KEY_TABLE_LEN] = '{
        8'h00, 8'h1B, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
        8'h2F, 8'h28, 8'h29, 8'h3D, 8'h3F, 8'h00, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h5E, 8'h2A, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
        8'h4C, 8'h4E, 8'h22, 8'h7C, 8'h00, 8'h5B,
        8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3B,
        8'h3A, 8'h5F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00
    };

    localparam t_byte ALTGR_KEYS [KEY_TABLE_LEN] = '{
        8'h00, 8'h00, 8'h7C, 8'h40, 8'h23, 8'h7E, 8'h00, 8'h00,
        8'h7B, 8'h5B, 8'h5D, 8'h7D, 8'h5C, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h5B, 8'h5D, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h7B, 8'h7D, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // Modifier presses and releases, and the bytes worth sending after 0xE0
    localparam t_byte MOD_KEYS [7] = '{
        SC_LSHIFT, SC_RSHIFT, SC_LCTRL, SC_CAPS,
        SC_LSHIFT | SC_BREAK, SC_RSHIFT | SC_BREAK, SC_LCTRL | SC_BREAK
    };
    localparam t_byte EXT_KEYS [6] = '{
        SC_ALT, SC_ALT | SC_BREAK, SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT
    };

    // Directed sequence: empty pop, shift/caps/ctrl, AltGr, prefixes, unmapped
    localparam int DIR_ROWS = 26;
    localparam t_key_row DIRECTED [DIR_ROWS] = '{
        '{MODE_POP,  8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{MODE_SCAN, 8'h02, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
        '{MODE_POP,  8'h00, 1'b1, '{8'h31, 1'b1, 1'b0, 1'b0}},
        '{MODE_SCAN, 8'h2A, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'h10, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'h3A, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'h1E, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'h2C, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'h02, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'hB6, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'h1D, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'h1E, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'hE0, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'h38, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'h03, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'h10, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'hE0, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'hB8, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'hE0, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'hE0, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'h48, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'h7F, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'hFF, 1'b0, NO_CHK},
        '{MODE_SCAN, 8'h00, 1'b0, NO_CHK},
        '{MODE_POP,  8'h00, 1'b0, NO_CHK},
        '{MODE_POP,  8'hAA, 1'b0, NO_CHK}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    sc2a_in_if  in_if ();
    sc2a_cfg_if cfg_if ();
    sc2a_out_if out_if ();

    scancode_to_ascii_fifo i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state
    t_byte       arrow_code [4];
    t_byte       ring_chars [$];
    logic        shift_dn;
    logic        ctrl_dn;
    logic        altgr_dn;
    logic        caps_latched;
    logic        e0_pending;

    t_key_result pending_results [$];
    int          fail_count   = 0;
    int          cycle_count  = 0;
    int          gapless_left = 0;
    logic        hold_off_req = 1'b0;

    function automatic logic letter_key(t_byte k);
        return k inside {[8'h10:8'h19], [8'h1E:8'h26], [8'h2C:8'h32]};
    endfunction

    // Returns 1 when the character is lost to a full ring
    function automatic logic push_char(t_byte c);
        if (c == 8'h00) return 1'b0;
        if (ring_chars.size() >= RING_CAP) return 1'b1;
        ring_chars.push_back(c);
        return 1'b0;
    endfunction

    function automatic logic decode_scan(t_byte b);
        t_byte c;
        logic  upper;
        if (b == SC_PREFIX) begin
            e0_pending = 1'b1;
            return 1'b0;
        end
        // Byte after the prefix: AltGr and arrows only
        if (e0_pending) begin
            e0_pending = 1'b0;
            if (b[7]) begin
                if ((b & SC_KEY_MASK) == SC_ALT) altgr_dn = 1'b0;
                return 1'b0;
            end
            case (b)
                SC_ALT:   altgr_dn = 1'b1;
                SC_UP:    return push_char(arrow_code[CFG_UP]);
                SC_DOWN:  return push_char(arrow_code[CFG_DOWN]);
                SC_LEFT:  return push_char(arrow_code[CFG_LEFT]);
                SC_RIGHT: return push_char(arrow_code[CFG_RIGHT]);
                default:  ;
            endcase
            return 1'b0;
        end
        // Releases only matter for shift and ctrl
        if (b[7]) begin
            c = b & SC_KEY_MASK;
            if (c == SC_LSHIFT || c == SC_RSHIFT) shift_dn = 1'b0;
            else if (c == SC_LCTRL) ctrl_dn = 1'b0;
            return 1'b0;
        end
        if (b == SC_LSHIFT || b == SC_RSHIFT) begin
            shift_dn = 1'b1;
        end else if (b == SC_LCTRL) begin
            ctrl_dn = 1'b1;
        end else if (b == SC_CAPS) begin
            caps_latched = ~caps_latched;
        end else if (b < KEY_TABLE_LEN) begin
            c = altgr_dn ? ALTGR_KEYS[b] : 8'h00;
            if (c == 8'h00) begin
                upper = shift_dn;
                if (letter_key(b)) upper = upper ^ caps_latched;
                c = upper ? UPPER_KEYS[b] : PLAIN_KEYS[b];
            end
            return push_char(c);
        end
        return 1'b0;
    endfunction

    function automatic t_key_result predict_step(logic m, t_byte b);
        t_key_result r;
        r = '0;
        if (m == MODE_POP) begin
            if (ring_chars.size() != 0) begin
                r.char_out   = ring_chars.pop_front();
                r.char_valid = 1'b1;
            end
        end else begin
            r.dropped = decode_scan(b);
        end
        r.has_key = (ring_chars.size() != 0);
        return r;
    endfunction

    // Sender gaps: mostly none or short, a few long, bursts with none
    function automatic int sender_gap();
        int r;
        if (gapless_left > 0) begin
            gapless_left = gapless_left - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) gapless_left = $urandom_range(20, 60);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one input transaction; valid stays high when the next follows at once
    task automatic send_item(input logic m, input t_byte b, input logic typed,
                             input t_key_result want);
        int          gap;
        t_key_result predicted;
        gap = sender_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.mode      <= m;
        in_if.scan_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predicted = predict_step(m, b);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic send_scan(input t_byte b);
        send_item(MODE_SCAN, b, 1'b0, NO_CHK);
    endtask

    // One keyboard event of one to three bytes, or a pop
    task automatic random_event(input int pop_pct, input int key_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < pop_pct) begin
            send_item(MODE_POP, t_byte'($urandom_range(0, 255)), 1'b0, NO_CHK);
        end else if ($urandom_range(0, 99) < key_pct) begin
            send_scan(t_byte'($urandom_range(0, KEY_TABLE_LEN - 1)));
        end else begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                send_scan(MOD_KEYS[$urandom_range(0, 6)]);
            end else if (r < 65) begin
                send_scan(SC_PREFIX);
                if ($urandom_range(0, 9) == 0) send_scan(SC_PREFIX);
                r = $urandom_range(0, 7);
                send_scan(r < 6 ? EXT_KEYS[r] : t_byte'($urandom_range(0, 255)));
            end else if (r < 80) begin
                send_scan(t_byte'($urandom_range(8'h80, 8'hFF)));
            end else begin
                send_scan(t_byte'($urandom_range(0, 255)));
            end
        end
    endtask

    // Drop valid and wait until every result is in, plus pipeline slack
    task automatic settle();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input t_byte val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        arrow_code[idx] = val;
    endtask

    task automatic load_arrow_codes(input t_arrow_codes codes);
        cfg_write(CFG_UP, codes.up);
        cfg_write(CFG_DOWN, codes.down);
        cfg_write(CFG_LEFT, codes.left);
        cfg_write(CFG_RIGHT, codes.right);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count = fail_count + 1;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_key_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got char %0h",
                         $time, out_if.char_out);
                fail_count = fail_count + 1;
            end else begin
                want = pending_results.pop_front();
                report_field("char_out", want.char_out, out_if.char_out);
                report_field("char_valid", want.char_valid, out_if.char_valid);
                report_field("has_key", want.has_key, out_if.has_key);
                report_field("dropped", want.dropped, out_if.dropped);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Receiver pacing, with one long hold-off on request
    initial begin : result_pacing
        int   run_left;
        logic rdy_now;
        run_left = 0;
        rdy_now  = 1'b0;
        forever begin
            if (hold_off_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
                run_left     = 0;
            end else begin
                if (run_left == 0) begin
                    rdy_now = ($urandom_range(0, 99) >= 35);
                    if (!rdy_now)
                        run_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                                 : $urandom_range(10, 40);
                    else
                        run_left = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 20)
                                                                 : $urandom_range(50, 120);
                end
                out_if.ready <= rdy_now;
                run_left = run_left - 1;
                @(posedge i_clk);
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.mode      <= MODE_SCAN;
        in_if.scan_byte <= 8'h00;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= CFG_UP;
        cfg_if.data     <= 8'h00;

        arrow_code[CFG_UP]    = UP_CODE_RST;
        arrow_code[CFG_DOWN]  = DOWN_CODE_RST;
        arrow_code[CFG_LEFT]  = LEFT_CODE_RST;
        arrow_code[CFG_RIGHT] = RIGHT_CODE_RST;
        shift_dn     = 1'b0;
        ctrl_dn      = 1'b0;
        altgr_dn     = 1'b0;
        caps_latched = 1'b0;
        e0_pending   = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with reset arrow codes
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIRECTED[i].mode, DIRECTED[i].scan, DIRECTED[i].typed,
                      DIRECTED[i].want);
        settle();

        // Mixed traffic, opened by a long receiver hold-off
        load_arrow_codes('{8'h00, 8'hFF, 8'h00, 8'hFF});
        hold_off_req = 1'b1;
        gapless_left = 60;
        repeat (120) random_event(30, 50);
        settle();

        // Typing with no pops: fills the ring and loses characters
        load_arrow_codes('{8'hFF, 8'h00, 8'hFF, 8'h00});
        repeat (330) random_event(0, 95);
        settle();

        // Pop-heavy traffic with random arrow codes
        load_arrow_codes('{t_byte'($urandom_range(0, 255)), t_byte'($urandom_range(0, 255)),
                           t_byte'($urandom_range(0, 255)), t_byte'($urandom_range(0, 255))});
        repeat (180) random_event(70, 50);
        settle();

        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

@@ scancode_to_ascii_fifo.f @@
+incdir+sv
sv/sc2a_pkg.sv
sv/sc2a_in_if.sv
sv/sc2a_out_if.sv
sv/sc2a_cfg_if.sv
sv/sc2a_ram.sv
sv/sc2a_decoder.sv
sv/scancode_to_ascii_fifo.sv
sim/tb.sv
